>>> rtl/core/bmhq_pkg.sv
`default_nettype none

package bmhq_pkg;

    // Field widths of the item and result beats
    localparam int CMD_W = 2;
    localparam int KEY_W = 32;
    localparam int PAY_W = 32;
    localparam int OCC_W = 11;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EXTRACT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

    // One heap entry as stored
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic start;      // capture the incoming entry, clear result
        logic ok_set;     // command will succeed
        logic cnt_clear;
        logic cnt_inc;
        logic cnt_dec;
        logic pos_load;   // hole position = entry count (insert)
        logic rd_ext;     // read root and last entry
        logic rd_up;      // read parent of hole
        logic rd_down;    // read both children of hole
        logic ext_load;   // take min from root, moving entry from last
        logic up_step;    // parent moves down into hole
        logic down_step;  // best child moves up into hole
        logic wr_x;       // moving entry lands in hole
        logic out_load;   // load result register
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic pos_zero;
        logic up_greater;
        logic down_move;
    } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/core/bmhq_ctrl.sv
`default_nettype none

module bmhq_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [bmhq_pkg::CMD_W-1:0]    command,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    input  wire bmhq_pkg::dp_status_t          status,
    output bmhq_pkg::ctl_cmd_t                 ctl
);
    import bmhq_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_UP_ISSUE = 3'd1;
    localparam logic [2:0] ST_UP_CMP   = 3'd2;
    localparam logic [2:0] ST_EXT_LOAD = 3'd3;
    localparam logic [2:0] ST_DN_ISSUE = 3'd4;
    localparam logic [2:0] ST_DN_CMP   = 3'd5;
    localparam logic [2:0] ST_FINISH   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        ctl            = '0;
        out_valid_next = out_valid_reg & ~out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.start  = 1'b1;
                    state_next = ST_FINISH;
                    case (command)
                        CMD_INSERT:
                        begin
                            if (!status.full)
                            begin
                                ctl.ok_set   = 1'b1;
                                ctl.pos_load = 1'b1;
                                ctl.cnt_inc  = 1'b1;
                                state_next   = ST_UP_ISSUE;
                            end
                        end
                        CMD_EXTRACT:
                        begin
                            if (!status.empty)
                            begin
                                ctl.ok_set = 1'b1;
                                ctl.rd_ext = 1'b1;
                                state_next = ST_EXT_LOAD;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            ctl.ok_set    = 1'b1;
                            ctl.cnt_clear = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_UP_ISSUE:
            begin
                if (status.pos_zero)
                begin
                    ctl.wr_x   = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    ctl.rd_up  = 1'b1;
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP:
            begin
                if (status.up_greater)
                begin
                    ctl.up_step = 1'b1;
                    state_next  = ST_UP_ISSUE;
                end
                else
                begin
                    ctl.wr_x   = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_EXT_LOAD:
            begin
                ctl.ext_load = 1'b1;
                ctl.cnt_dec  = 1'b1;
                state_next   = ST_DN_ISSUE;
            end
            ST_DN_ISSUE:
            begin
                ctl.rd_down = 1'b1;
                state_next  = ST_DN_CMP;
            end
            ST_DN_CMP:
            begin
                if (status.down_move)
                begin
                    ctl.down_step = 1'b1;
                    state_next    = ST_DN_ISSUE;
                end
                else
                begin
                    ctl.wr_x   = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // result register free or being emptied this cycle
                if (!out_valid_reg || out_ready)
                begin
                    ctl.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/bmhq_datapath.sv
`default_nettype none

module bmhq_datapath #(
    parameter int CAPACITY = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [bmhq_pkg::KEY_W-1:0]    key,
    input  wire logic [bmhq_pkg::PAY_W-1:0]    payload,
    input  wire bmhq_pkg::ctl_cmd_t            ctl,
    output bmhq_pkg::dp_status_t               status,
    output logic                               ok,
    output logic [bmhq_pkg::KEY_W-1:0]         min_key,
    output logic [bmhq_pkg::PAY_W-1:0]         min_payload,
    output logic                               empty_res,
    output logic [bmhq_pkg::OCC_W-1:0]         occupancy
);
    import bmhq_pkg::*;

    localparam int AW     = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CW     = AW + 1;
    localparam int WIDE_W = (CNT_W > OCC_W) ? CNT_W : OCC_W;

    // Heap storage: one write port, two registered read ports
    entry_t mem [CAPACITY];

    entry_t             rd_a_reg;
    entry_t             rd_b_reg;
    entry_t             x_reg;
    logic [AW-1:0]      pos_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               ok_reg;
    logic [KEY_W-1:0]   mk_reg;
    logic [PAY_W-1:0]   mp_reg;

    logic               ok_out_reg;
    logic [KEY_W-1:0]   min_key_reg;
    logic [PAY_W-1:0]   min_payload_reg;
    logic               empty_out_reg;
    logic [OCC_W-1:0]   occ_out_reg;

    logic [CNT_W-1:0]   last_idx;
    logic [CW-1:0]      cnt_ext;
    logic [CW-1:0]      lc;
    logic [CW-1:0]      rc;
    logic               lc_take;
    logic               rc_take;
    logic [KEY_W-1:0]   best_key;
    logic [CW-1:0]      best_idx;
    logic [WIDE_W-1:0]  cnt_wide;

    logic               rd_en;
    logic [AW-1:0]      rd_addr_a;
    logic [AW-1:0]      rd_addr_b;
    logic               wr_en;
    entry_t             wr_data;

    assign last_idx = count_reg - CNT_W'(1);
    assign cnt_ext  = CW'(count_reg);
    assign cnt_wide = WIDE_W'(count_reg);

    // Children of the hole; the root's left child is itself and never counts
    assign lc       = {pos_reg, 1'b0};
    assign rc       = {pos_reg, 1'b1};
    assign lc_take  = (pos_reg != '0) && (lc < cnt_ext) && (rd_a_reg.key < x_reg.key);
    assign best_key = lc_take ? rd_a_reg.key : x_reg.key;
    assign rc_take  = (rc < cnt_ext) && (rd_b_reg.key < best_key);
    assign best_idx = rc_take ? rc : lc;

    // Status back to the controller
    assign status.full       = (count_reg == CNT_W'(CAPACITY));
    assign status.empty      = (count_reg == '0);
    assign status.pos_zero   = (pos_reg == '0);
    assign status.up_greater = (rd_a_reg.key > x_reg.key);
    assign status.down_move  = lc_take | rc_take;

    // Read address select
    always_comb
    begin
        rd_addr_a = '0;
        rd_addr_b = last_idx[AW-1:0];
        if (ctl.rd_up)
        begin
            rd_addr_a = pos_reg >> 1;
        end
        else if (ctl.rd_down)
        begin
            rd_addr_a = lc[AW-1:0];
            rd_addr_b = rc[AW-1:0];
        end
    end

    assign rd_en = ctl.rd_ext | ctl.rd_up | ctl.rd_down;

    // Write into the hole
    always_comb
    begin
        wr_en   = ctl.wr_x | ctl.up_step | ctl.down_step;
        wr_data = rd_a_reg;
        if (ctl.wr_x)
        begin
            wr_data = x_reg;
        end
        else if (ctl.down_step && rc_take)
        begin
            wr_data = rd_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[pos_reg] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    // Entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctl.cnt_clear)
        begin
            count_reg <= '0;
        end
        else if (ctl.cnt_inc)
        begin
            count_reg <= count_reg + CNT_W'(1);
        end
        else if (ctl.cnt_dec)
        begin
            count_reg <= last_idx;
        end
    end

    // Hole position, moving entry and working result
    always_ff @(posedge clk)
    begin
        if (ctl.pos_load)
        begin
            pos_reg <= count_reg[AW-1:0];
        end
        else if (ctl.ext_load)
        begin
            pos_reg <= '0;
        end
        else if (ctl.up_step)
        begin
            pos_reg <= pos_reg >> 1;
        end
        else if (ctl.down_step)
        begin
            pos_reg <= best_idx[AW-1:0];
        end

        if (ctl.start)
        begin
            x_reg.key     <= key;
            x_reg.payload <= payload;
            mk_reg        <= '0;
            mp_reg        <= '0;
            ok_reg        <= ctl.ok_set;
        end
        else if (ctl.ext_load)
        begin
            x_reg  <= rd_b_reg;
            mk_reg <= rd_a_reg.key;
            mp_reg <= rd_a_reg.payload;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            ok_out_reg      <= ok_reg;
            min_key_reg     <= mk_reg;
            min_payload_reg <= mp_reg;
            empty_out_reg   <= (count_reg == '0);
            occ_out_reg     <= cnt_wide[OCC_W-1:0];
        end
    end

    assign ok          = ok_out_reg;
    assign min_key     = min_key_reg;
    assign min_payload = min_payload_reg;
    assign empty_res   = empty_out_reg;
    assign occupancy   = occ_out_reg;

endmodule

`default_nettype wire

>>> rtl/core/binary_min_heap_queue_core.sv
// Bounded min-priority queue of CAPACITY entries kept as an array heap.
// Input beat (in_valid/in_ready): command, key, payload. Command insert adds
// the entry, extract removes the smallest key, clear empties the queue.
// Output beat (out_valid/out_ready): ok, min_key, min_payload, empty_res and
// occupancy after the command; one output beat per input beat, in order.
// One command is worked at a time. The heap lives in a RAM with one write and
// two registered read ports; each tree level of the sift loop takes a read step
// and then a compare/write step, so the number of levels sifted sets the time
// per beat. Insert climbs from the new last entry toward the root; extract
// sinks the moved last entry from the root. Clear, refused and unknown
// commands do no sift. With 1024 entries an entry climbs or sinks at most
// 10 levels.
// in_ready is high whenever no command is being worked, even while a result
// waits in the output register; a stalled receiver holds that result and the
// next command then waits in its finish state until the register frees.
// Reset empties the queue and drops any pending result; stored entries are
// not cleared and need no clearing pass.
`default_nettype none

module binary_min_heap_queue_core #(
    parameter int CAPACITY = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [bmhq_pkg::CMD_W-1:0]    command,
    input  wire logic [bmhq_pkg::KEY_W-1:0]    key,
    input  wire logic [bmhq_pkg::PAY_W-1:0]    payload,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               ok,
    output logic [bmhq_pkg::KEY_W-1:0]         min_key,
    output logic [bmhq_pkg::PAY_W-1:0]         min_payload,
    output logic                               empty_res,
    output logic [bmhq_pkg::OCC_W-1:0]         occupancy
);
    import bmhq_pkg::*;

    ctl_cmd_t   ctl;
    dp_status_t status;

    // Sequencer
    bmhq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .ctl       (ctl)
    );

    // Heap storage and sift datapath
    bmhq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .key         (key),
        .payload     (payload),
        .ctl         (ctl),
        .status      (status),
        .ok          (ok),
        .min_key     (min_key),
        .min_payload (min_payload),
        .empty_res   (empty_res),
        .occupancy   (occupancy)
    );

endmodule

`default_nettype wire
